>>> rtl/sbpa_pkg.sv
package sbpa_pkg;

  localparam int NUM_SEGMENTS = 64;
  localparam int SEG_BITS     = 16;
  localparam int TOTAL_PAGES  = NUM_SEGMENTS * SEG_BITS;

  localparam int SEG_W        = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int SEG_CNT_W    = $clog2(NUM_SEGMENTS + 1);
  localparam int OFF_W        = $clog2(SEG_BITS);
  localparam int N_W          = $clog2(SEG_BITS + 1);

  localparam int CNT_W        = 11;
  localparam int START_W      = 10;
  localparam int PAGE_OUT_W   = 10;
  localparam int PAGE_RAW_W   = $clog2(TOTAL_PAGES + SEG_BITS);
  localparam int PAGE_W       = (PAGE_RAW_W > START_W + 1) ? PAGE_RAW_W : START_W + 1;

  localparam int S_TDATA_W    = 24;
  localparam int M_TDATA_W    = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic alloc_commit;
    logic free_commit;
    logic res_fail;
    logic res_free;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic count_bad;
    logic free_none;
    logic hit;
    logic scan_end;
    logic free_last;
    logic out_busy;
  } sts_t;

endpackage

>>> rtl/sbpa_datapath.sv
module sbpa_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [sbpa_pkg::S_TDATA_W-1:0] s_tdata,  // page_count[10:0], start_page[20:11]
  input  logic [0:0]                     s_tuser,  // func[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sbpa_pkg::M_TDATA_W-1:0] m_tdata,  // first_page[9:0]
  output logic [0:0]                     m_tuser,  // ok[0]
  input  sbpa_pkg::cmd_t                 cmd,
  output sbpa_pkg::sts_t                 sts
);
  import sbpa_pkg::*;

  logic                  func_r;
  logic [CNT_W-1:0]      left;
  logic [PAGE_W-1:0]     page;
  logic [SEG_CNT_W-1:0]  rd_seg;
  logic [SEG_W-1:0]      data_seg;

  logic [SEG_BITS-1:0]   mem [NUM_SEGMENTS];
  logic                  vbits [NUM_SEGMENTS];
  logic [SEG_BITS-1:0]   rd_data;
  logic                  rd_vld;

  logic                  res_ok;
  logic [PAGE_OUT_W-1:0] res_page;
  logic                  out_ok;
  logic [PAGE_OUT_W-1:0] out_page;

  logic [SEG_BITS-1:0]   seg_val;
  logic [SEG_BITS-1:0]   amask;
  logic [SEG_BITS-1:0]   fit;
  logic [OFF_W-1:0]      hit_off;
  logic [OFF_W-1:0]      lo;
  logic [N_W-1:0]        room;
  logic [N_W-1:0]        n;
  logic [SEG_BITS-1:0]   fmask;
  logic [PAGE_W-1:0]     page_sum;
  logic [SEG_BITS-1:0]   wr_data;
  logic                  wr_en;

  // never-written segments read as fully allocated
  assign seg_val = rd_vld ? rd_data : '0;

  // first fit inside the segment just read
  always_comb begin
    amask   = SEG_BITS'((32'd1 << left) - 32'd1);
    hit_off = '0;
    for (int i = 0; i < SEG_BITS; i++) begin
      fit[i] = (((CNT_W + 1)'(i) + (CNT_W + 1)'(left)) <= (CNT_W + 1)'(SEG_BITS)) &&
               (((seg_val >> i) & amask) == amask);
    end
    for (int i = SEG_BITS - 1; i >= 0; i--) begin
      if (fit[i]) begin
        hit_off = OFF_W'(i);
      end
    end
  end

  // bits of the free range that land in the current segment
  always_comb begin
    lo       = page[OFF_W-1:0];
    room     = N_W'(SEG_BITS) - N_W'(lo);
    n        = (left < CNT_W'(room)) ? N_W'(left) : room;
    fmask    = SEG_BITS'(((32'd1 << n) - 32'd1) << lo);
    page_sum = page + PAGE_W'(n);
  end

  assign wr_en   = cmd.alloc_commit | cmd.free_commit;
  assign wr_data = cmd.alloc_commit ? (seg_val & ~(amask << hit_off)) : (seg_val | fmask);

  always_comb begin
    sts.is_free   = func_r;
    sts.count_bad = (left == '0) || (left > CNT_W'(SEG_BITS));
    sts.free_none = (left == '0) || (page >= PAGE_W'(TOTAL_PAGES));
    sts.hit       = |fit;
    sts.scan_end  = (rd_seg == SEG_CNT_W'(NUM_SEGMENTS));
    sts.free_last = (left == CNT_W'(n)) || (page_sum >= PAGE_W'(TOTAL_PAGES));
    sts.out_busy  = m_tvalid && !m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_seg[SEG_W-1:0]];
    end
    if (wr_en) begin
      mem[data_seg] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEGMENTS; i++) begin
        vbits[i] <= 1'b0;
      end
      rd_vld <= 1'b0;
    end else begin
      if (cmd.rd_issue) begin
        rd_vld <= vbits[rd_seg[SEG_W-1:0]];
      end
      if (wr_en) begin
        vbits[data_seg] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= s_tuser[0];
      left   <= s_tdata[CNT_W-1:0];
      page   <= PAGE_W'(s_tdata[CNT_W+START_W-1:CNT_W]);
      rd_seg <= s_tuser[0] ? SEG_CNT_W'(s_tdata[CNT_W+START_W-1:CNT_W+OFF_W]) : '0;
    end else begin
      if (cmd.rd_issue) begin
        data_seg <= rd_seg[SEG_W-1:0];
        rd_seg   <= rd_seg + 1'b1;
      end
      if (cmd.free_commit) begin
        page <= page_sum;
        left <= left - CNT_W'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      res_ok   <= 1'b1;
      res_page <= PAGE_OUT_W'({data_seg, hit_off});
    end else if (cmd.res_fail) begin
      res_ok   <= 1'b0;
      res_page <= '0;
    end else if (cmd.res_free) begin
      res_ok   <= 1'b1;
      res_page <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok   <= res_ok;
      out_page <= res_page;
    end
  end

  assign m_tdata = {{(M_TDATA_W - PAGE_OUT_W){1'b0}}, out_page};
  assign m_tuser = out_ok;

endmodule

>>> rtl/sbpa_ctrl.sv
module sbpa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  sbpa_pkg::sts_t sts,
  output sbpa_pkg::cmd_t cmd
);
  import sbpa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (sts.is_free) begin
          if (sts.free_none) begin
            cmd.res_free = 1'b1;
            state_next   = ST_DONE;
          end else begin
            cmd.rd_issue = 1'b1;
            state_next   = ST_FREE;
          end
        end else if (sts.count_bad) begin
          cmd.res_fail = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.alloc_commit = 1'b1;
          state_next       = ST_DONE;
        end else if (sts.scan_end) begin
          cmd.res_fail = 1'b1;
          state_next   = ST_DONE;
        end else begin
          // keep one segment read in flight
          cmd.rd_issue = 1'b1;
        end
      end
      ST_FREE: begin
        cmd.free_commit = 1'b1;
        if (sts.free_last) begin
          cmd.res_free = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/segmented_bitmap_page_allocator_top.sv
// Allocate returns the first fit found scanning segments in order; a failed scan or a bad count
//   returns ok low with page zero. Free sets the bits of the range segment by segment.
// Only one request is handled at a time; the map RAM port reads one segment per cycle.
// Reset: rst clears the controller, the output valid and the per-segment valid
//   bits at once, so the whole map reads as allocated on the next cycle.
module segmented_bitmap_page_allocator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [sbpa_pkg::S_TDATA_W-1:0] s_tdata,  // page_count[10:0], start_page[20:11]
  input  logic [0:0]                     s_tuser,  // func[0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [sbpa_pkg::M_TDATA_W-1:0] m_tdata,  // first_page[9:0]
  output logic [0:0]                     m_tuser   // ok[0]
);
  import sbpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbpa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  a_fail_page_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("failed allocation reports a nonzero page");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !$rose(m_tvalid))
    else $error("result appeared one cycle after input transfer");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while the input side was open");

endmodule
